// ===== rtl/core/ctpq_pkg.sv =====
// Shared types, constants and the command byte table of the camera tracking preset queue.
package ctpq_pkg;

    // Default sizing of the tracking list and of the unit key.
    localparam int LIST_DEPTH_DEF   = 32;
    localparam int UNIT_ID_BITS_DEF = 12;

    // Fixed field widths.
    localparam int UNIT_ID_W = 12;
    localparam int BYTE_W    = 8;
    localparam int CH_W      = 3;    // stored channels are always 1..5
    localparam int SEQ_W     = 4;    // byte position within the two frames
    localparam int ADDR_W    = 3;

    // Valid call channels.
    localparam logic [BYTE_W-1:0] CH_MIN = 8'd1;
    localparam logic [BYTE_W-1:0] CH_MAX = 8'd5;

    // Request codes.
    localparam logic REQ_CALL    = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Register index, taken from paddr bit 2.
    localparam logic REG_PAN_CHANNEL = 1'b0;
    localparam logic REG_PAN_PRESET  = 1'b1;

    // Frame constants.
    localparam logic [BYTE_W-1:0] B_ZERO     = 8'h00;
    localparam logic [BYTE_W-1:0] B_ONE      = 8'h01;
    localparam logic [BYTE_W-1:0] B_TERM     = 8'hFF;
    localparam logic [BYTE_W-1:0] B_SW_CMD   = 8'h10;
    localparam logic [BYTE_W-1:0] B_SW_SUB   = 8'hFB;
    localparam logic [BYTE_W-1:0] B_SW_SUM   = 8'h0B;
    localparam logic [BYTE_W-1:0] B_CAM_ADDR = 8'h80;
    localparam logic [BYTE_W-1:0] B_CAM_CMD  = 8'h04;
    localparam logic [BYTE_W-1:0] B_RECALL   = 8'h3F;
    localparam logic [BYTE_W-1:0] B_RCL_SUB  = 8'h02;

    // Byte positions of the frame ends and of the first recall byte.
    localparam logic [SEQ_W-1:0] SEQ_SWITCH_END = 4'd8;
    localparam logic [SEQ_W-1:0] SEQ_RECALL     = 4'd9;
    localparam logic [SEQ_W-1:0] SEQ_LAST       = 4'd15;

    // Shift controls broadcast along the row of list cells.
    typedef struct packed {
        logic shift_up;     // insert a new entry at the head
        logic shift_down;   // close the gap left by a removed entry
        logic found;        // the key is held in the list
    } cell_ctl_t;

    // Byte k of the switch frame (0..8) followed by the recall frame (9..15).
    function automatic logic [BYTE_W-1:0] frame_byte(
        input logic [SEQ_W-1:0]  k,
        input logic [BYTE_W-1:0] ch,
        input logic [BYTE_W-1:0] pos
    );
        logic [BYTE_W-1:0] b;
        unique case (k)
            4'd0:    b = B_ZERO;
            4'd1:    b = B_ONE;
            4'd2:    b = B_TERM;
            4'd3:    b = B_SW_CMD;
            4'd4:    b = B_ZERO;
            4'd5:    b = B_SW_SUB;
            4'd6:    b = B_ZERO;
            4'd7:    b = ch;
            4'd8:    b = B_SW_SUM + ch;
            4'd9:    b = B_CAM_ADDR + ch;
            4'd10:   b = B_ONE;
            4'd11:   b = B_CAM_CMD;
            4'd12:   b = B_RECALL;
            4'd13:   b = B_RCL_SUB;
            4'd14:   b = pos;
            default: b = B_TERM;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/ctpq_if.sv =====
// Handshake interfaces for the event input and the command byte output.
interface ctpq_evt_if;
    logic                           valid;
    logic                           ready;
    logic                           req_type;
    logic [ctpq_pkg::UNIT_ID_W-1:0] unit_id;
    logic                           is_wifi;
    logic [ctpq_pkg::BYTE_W-1:0]    cam_channel;
    logic [ctpq_pkg::BYTE_W-1:0]    cam_preset;

    modport source (output valid, req_type, unit_id, is_wifi, cam_channel, cam_preset,
                    input ready);
    modport sink   (input valid, req_type, unit_id, is_wifi, cam_channel, cam_preset,
                    output ready);
endinterface

interface ctpq_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [ctpq_pkg::BYTE_W-1:0] cmd_byte;
    logic                        end_of_command;
    logic                        last;

    modport source (output valid, cmd_byte, end_of_command, last, input ready);
    modport sink   (input valid, cmd_byte, end_of_command, last, output ready);
endinterface

// ===== rtl/core/ctpq_cell.sv =====
// One tracking list cell: holds one entry, matches the broadcast key, shifts with its neighbours.
module ctpq_cell #(
    parameter int KEY_W = 13,
    parameter int IDX_W = 5,
    parameter int CNT_W = 6,
    parameter int POS   = 0
) (
    input  logic                          clk,
    input  ctpq_pkg::cell_ctl_t           ctl,
    input  logic [CNT_W-1:0]              count,
    input  logic [IDX_W-1:0]              idx,
    input  logic [KEY_W-1:0]              key,
    input  logic [KEY_W-1:0]              left_key,
    input  logic [ctpq_pkg::CH_W-1:0]     left_ch,
    input  logic [ctpq_pkg::BYTE_W-1:0]   left_pos,
    input  logic [KEY_W-1:0]              right_key,
    input  logic [ctpq_pkg::CH_W-1:0]     right_ch,
    input  logic [ctpq_pkg::BYTE_W-1:0]   right_pos,
    output logic [KEY_W-1:0]              key_q,
    output logic [ctpq_pkg::CH_W-1:0]     ch_q,
    output logic [ctpq_pkg::BYTE_W-1:0]   pos_q,
    output logic                          match
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(POS);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(POS);

    logic [KEY_W-1:0]            key_reg;
    logic [ctpq_pkg::CH_W-1:0]   ch_reg;
    logic [ctpq_pkg::BYTE_W-1:0] pos_reg;
    logic                        take_left;
    logic                        take_right;

    // The entry is live only below the fill count.
    assign match = (MY_CNT < count) && (key_reg == key);

    // Insertion moves every cell up to the removed one (or all of them) one place towards the
    // tail; removal pulls every cell from the gap onwards one place towards the head.
    assign take_left  = ctl.shift_up && (!ctl.found || (MY_IDX <= idx));
    assign take_right = ctl.shift_down && (MY_IDX >= idx);

    always_ff @(posedge clk)
    begin
        if (take_left)
        begin
            key_reg <= left_key;
            ch_reg  <= left_ch;
            pos_reg <= left_pos;
        end
        else if (take_right)
        begin
            key_reg <= right_key;
            ch_reg  <= right_ch;
            pos_reg <= right_pos;
        end
    end

    assign key_q = key_reg;
    assign ch_q  = ch_reg;
    assign pos_q = pos_reg;

endmodule

// ===== rtl/core/camera_tracking_preset_queue_unit.sv =====
// Top level of the camera tracking preset queue: list control, command serialiser and registers.
//
//  channel | kind          | direction | carries
//  --------+---------------+-----------+-------------------------------------------------
//  evt     | valid/ready   | in        | req_type, unit_id, is_wifi, cam_channel, cam_preset
//  cmd     | valid/ready   | out       | cmd_byte, end_of_command, last
//  apb     | APB, pready=1 | in        | panorama_channel (0x0), panorama_preset (0x4)
//
// An event passes through transfer, key lookup and list update when it yields no bytes.
// An event that aims the camera then sends one command byte per cycle while the sink stays
// ready: 7 bytes for a preset recall alone, 16 with a channel switch.
// The list itself updates in the list update step, all cells at once.
// The output register holds the final byte while the next event is taken; a stalled sink
// stops the serialiser. Reset clears the fill count, so no clearing pass is needed.
module camera_tracking_preset_queue_unit #(
    parameter int LIST_DEPTH   = ctpq_pkg::LIST_DEPTH_DEF,
    parameter int UNIT_ID_BITS = ctpq_pkg::UNIT_ID_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    ctpq_evt_if.sink                     evt,
    ctpq_cmd_if.source                   cmd,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ctpq_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int KEY_W = UNIT_ID_BITS + 1;
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int BW    = ctpq_pkg::BYTE_W;
    localparam int CW    = ctpq_pkg::CH_W;
    localparam int SW    = ctpq_pkg::SEQ_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_SEND   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic             req_reg;
    logic [KEY_W-1:0] key_reg;
    logic [BW-1:0]    ch_reg;
    logic [BW-1:0]    pos_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             found_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [BW-1:0]    cur_ch_reg;
    logic [BW-1:0]    aim_ch_reg;
    logic [BW-1:0]    aim_pos_reg;
    logic [SW-1:0]    seq_reg;
    logic             out_valid_reg;
    logic [BW-1:0]    out_byte_reg;
    logic             out_eoc_reg;
    logic             out_last_reg;
    logic [BW-1:0]    pan_ch_reg;
    logic [BW-1:0]    pan_pos_reg;

    logic [UNIT_ID_BITS+ctpq_pkg::UNIT_ID_W-1:0] id_wide;
    logic [KEY_W-1:0] evt_key;

    logic [KEY_W-1:0] cell_key  [LIST_DEPTH];
    logic [CW-1:0]    cell_ch   [LIST_DEPTH];
    logic [BW-1:0]    cell_pos  [LIST_DEPTH];
    logic [KEY_W-1:0] left_key  [LIST_DEPTH];
    logic [CW-1:0]    left_ch   [LIST_DEPTH];
    logic [BW-1:0]    left_pos  [LIST_DEPTH];
    logic [KEY_W-1:0] right_key [LIST_DEPTH];
    logic [CW-1:0]    right_ch  [LIST_DEPTH];
    logic [BW-1:0]    right_pos [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] match;
    logic [IDX_W-1:0] match_idx;

    ctpq_pkg::cell_ctl_t ctl;
    logic             call_ok;
    logic             rel_head;
    logic             do_aim;
    logic [BW-1:0]    aim_ch;
    logic [BW-1:0]    aim_pos;
    logic             load_byte;
    logic             cfg_wr;

    // Unit key: wireless flag above the used unit number bits.
    assign id_wide = (UNIT_ID_BITS + ctpq_pkg::UNIT_ID_W)'(evt.unit_id);
    assign evt_key = {evt.is_wifi, id_wide[UNIT_ID_BITS-1:0]};

    // Row of list cells; cell 0 holds the newest entry and takes new entries from the left.
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left_key[i] = key_reg;
            assign left_ch[i]  = ch_reg[CW-1:0];
            assign left_pos[i] = pos_reg;
        end
        else
        begin : g_body
            assign left_key[i] = cell_key[i-1];
            assign left_ch[i]  = cell_ch[i-1];
            assign left_pos[i] = cell_pos[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_tail
            assign right_key[i] = '0;
            assign right_ch[i]  = '0;
            assign right_pos[i] = '0;
        end
        else
        begin : g_inner
            assign right_key[i] = cell_key[i+1];
            assign right_ch[i]  = cell_ch[i+1];
            assign right_pos[i] = cell_pos[i+1];
        end

        ctpq_cell #(
            .KEY_W (KEY_W),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .POS   (i)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .count     (count_reg),
            .idx       (idx_reg),
            .key       (key_reg),
            .left_key  (left_key[i]),
            .left_ch   (left_ch[i]),
            .left_pos  (left_pos[i]),
            .right_key (right_key[i]),
            .right_ch  (right_ch[i]),
            .right_pos (right_pos[i]),
            .key_q     (cell_key[i]),
            .ch_q      (cell_ch[i]),
            .pos_q     (cell_pos[i]),
            .match     (match[i])
        );
    end

    // Keys are unique in the list, so the match vector is one-hot or empty.
    always_comb
    begin
        match_idx = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (match[i])
            begin
                match_idx = match_idx | IDX_W'(i);
            end
        end
    end

    // Update decisions, valid in the update cycle.
    assign call_ok  = (req_reg == ctpq_pkg::REQ_CALL)
                      && (ch_reg >= ctpq_pkg::CH_MIN) && (ch_reg <= ctpq_pkg::CH_MAX);
    assign rel_head = (req_reg == ctpq_pkg::REQ_RELEASE) && found_reg && (idx_reg == '0);
    assign do_aim   = call_ok || rel_head;

    always_comb
    begin
        ctl.shift_up   = (state_reg == ST_UPDATE) && call_ok;
        ctl.shift_down = (state_reg == ST_UPDATE)
                         && (req_reg == ctpq_pkg::REQ_RELEASE) && found_reg;
        ctl.found      = found_reg;
    end

    // Aim target: the caller, the entry behind the released head, or the panorama view.
    always_comb
    begin
        priority if (call_ok)
        begin
            aim_ch  = ch_reg;
            aim_pos = pos_reg;
        end
        else if (count_reg > CNT_W'(1))
        begin
            aim_ch  = BW'(cell_ch[1]);
            aim_pos = cell_pos[1];
        end
        else
        begin
            aim_ch  = pan_ch_reg;
            aim_pos = pan_pos_reg;
        end
    end

    // Fill count: grows on a call for a new unit until full, shrinks on a removal.
    always_comb
    begin
        count_next = count_reg;
        if (ctl.shift_up && !found_reg && (count_reg != CNT_W'(LIST_DEPTH)))
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.shift_down)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // The serialiser loads a byte whenever the output register is free or being emptied.
    assign load_byte = (state_reg == ST_SEND) && (!out_valid_reg || cmd.ready);

    // Sequencer state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt.valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = do_aim ? ST_SEND : ST_IDLE;
            end
            default:
            begin
                if (load_byte && (seq_reg == ctpq_pkg::SEQ_LAST))
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            cur_ch_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if ((state_reg == ST_UPDATE) && do_aim)
            begin
                cur_ch_reg <= aim_ch;
            end
        end
    end

    // Event capture, lookup result and aim operands.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && evt.valid)
        begin
            req_reg <= evt.req_type;
            key_reg <= evt_key;
            ch_reg  <= evt.cam_channel;
            pos_reg <= evt.cam_preset;
        end
        if (state_reg == ST_LOOKUP)
        begin
            idx_reg   <= match_idx;
            found_reg <= |match;
        end
        if ((state_reg == ST_UPDATE) && do_aim)
        begin
            aim_ch_reg  <= aim_ch;
            aim_pos_reg <= aim_pos;
            seq_reg     <= (cur_ch_reg != aim_ch) ? '0 : ctpq_pkg::SEQ_RECALL;
        end
        else if (load_byte)
        begin
            seq_reg <= seq_reg + SW'(1);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (cmd.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_byte)
        begin
            out_byte_reg <= ctpq_pkg::frame_byte(seq_reg, aim_ch_reg, aim_pos_reg);
            out_eoc_reg  <= (seq_reg == ctpq_pkg::SEQ_SWITCH_END)
                            || (seq_reg == ctpq_pkg::SEQ_LAST);
            out_last_reg <= (seq_reg == ctpq_pkg::SEQ_LAST);
        end
    end

    assign evt.ready          = (state_reg == ST_IDLE);
    assign cmd.valid          = out_valid_reg;
    assign cmd.cmd_byte       = out_byte_reg;
    assign cmd.end_of_command = out_eoc_reg;
    assign cmd.last           = out_last_reg;

    // Configuration registers.
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_ch_reg  <= 8'd1;
            pan_pos_reg <= 8'd0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                ctpq_pkg::REG_PAN_CHANNEL: pan_ch_reg  <= pwdata[BW-1:0];
                default:                   pan_pos_reg <= pwdata[BW-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ctpq_pkg::REG_PAN_CHANNEL: prdata = 32'(pan_ch_reg);
            default:                   prdata = 32'(pan_pos_reg);
        endcase
    end

    assign pready = 1'b1;

endmodule

// ===== rtl/core/ctpq_checker.sv =====
// Port-level checks for the camera tracking preset queue, bound to the top level.
module ctpq_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        evt_valid,
    input logic                        evt_ready,
    input logic                        cmd_valid,
    input logic                        cmd_ready,
    input logic [ctpq_pkg::BYTE_W-1:0] cmd_byte,
    input logic                        cmd_end_of_command,
    input logic                        cmd_last,
    input logic                        pready
);

    // A stalled command byte keeps its value.
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_byte) && $stable(cmd_last))
        else $error("command byte changed while stalled");

    // The final byte of an event always closes a frame.
    a_last_eoc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_last |-> cmd_end_of_command)
        else $error("last byte without end of command");

    // Two events are never taken back to back: a transfer always leaves the block busy.
    a_evt_busy: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready |=> !evt_ready)
        else $error("event taken in consecutive cycles");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind camera_tracking_preset_queue_unit ctpq_checker u_ctpq_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .evt_valid          (evt.valid),
    .evt_ready          (evt.ready),
    .cmd_valid          (cmd.valid),
    .cmd_ready          (cmd.ready),
    .cmd_byte           (cmd.cmd_byte),
    .cmd_end_of_command (cmd.end_of_command),
    .cmd_last           (cmd.last),
    .pready             (pready)
);

// ===== test/ctpq_command_checker.sv =====
// Scoreboard for the tracking preset queue: mirrors the speaker list, checks each command byte.
module ctpq_command_checker
    import ctpq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    ctpq_evt_if               evt,
    ctpq_cmd_if               cmd,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output int                fail_count,
    output int                bytes_pending
);

    localparam int DEPTH      = LIST_DEPTH_DEF;
    localparam int ID_BITS    = UNIT_ID_BITS_DEF;
    localparam int KEY_W      = ID_BITS + 1;
    localparam int REPORT_MAX = 10;

    // One expected byte on the command channel.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              eoc;
        logic              last;
    } cmd_beat_t;

    cmd_beat_t         cmd_expected[$];

    // Mirror of the speaker list: entry 0 is the oldest, speaker_count-1 the newest.
    logic [KEY_W-1:0]  speaker_key [DEPTH];
    logic [BYTE_W-1:0] speaker_channel [DEPTH];
    logic [BYTE_W-1:0] speaker_preset [DEPTH];
    int                speaker_count;
    logic [BYTE_W-1:0] live_channel;
    logic [BYTE_W-1:0] pan_channel;
    logic [BYTE_W-1:0] pan_preset;
    int                mismatch_count;

    assign fail_count = mismatch_count;

    // Position of a unit key in the list, or -1 when it is not listed.
    function automatic int find_speaker(input logic [KEY_W-1:0] key);
        for (int i = 0; i < speaker_count; i++)
        begin
            if (speaker_key[i] == key)
                return i;
        end
        return -1;
    endfunction

    // Remove one entry and close the gap behind it.
    function automatic void drop_speaker(input int idx);
        for (int i = idx; i + 1 < speaker_count; i++)
        begin
            speaker_key[i]     = speaker_key[i + 1];
            speaker_channel[i] = speaker_channel[i + 1];
            speaker_preset[i]  = speaker_preset[i + 1];
        end
        speaker_count--;
    endfunction

    function automatic void push_beat(input logic [BYTE_W-1:0] data, input logic eoc);
        cmd_beat_t beat;
        beat.data = data;
        beat.eoc  = eoc;
        beat.last = 1'b0;
        cmd_expected.push_back(beat);
    endfunction

    // Channel switch frame when the channel changes, then the preset recall frame.
    function automatic void aim_camera(
        input logic [BYTE_W-1:0] ch,
        input logic [BYTE_W-1:0] pos
    );
        if (live_channel != ch)
        begin
            live_channel = ch;
            push_beat(B_ZERO, 1'b0);
            push_beat(B_ONE, 1'b0);
            push_beat(B_TERM, 1'b0);
            push_beat(B_SW_CMD, 1'b0);
            push_beat(B_ZERO, 1'b0);
            push_beat(B_SW_SUB, 1'b0);
            push_beat(B_ZERO, 1'b0);
            push_beat(ch, 1'b0);
            push_beat(B_SW_SUM + ch, 1'b1);
        end
        push_beat(B_CAM_ADDR + ch, 1'b0);
        push_beat(B_ONE, 1'b0);
        push_beat(B_CAM_CMD, 1'b0);
        push_beat(B_RECALL, 1'b0);
        push_beat(B_RCL_SUB, 1'b0);
        push_beat(pos, 1'b0);
        push_beat(B_TERM, 1'b1);
    endfunction

    // Update the list for one event and queue the bytes it must produce.
    function automatic void predict_event(
        input logic                 req,
        input logic [UNIT_ID_W-1:0] id,
        input logic                 wifi,
        input logic [BYTE_W-1:0]    ch,
        input logic [BYTE_W-1:0]    pos
    );
        logic [KEY_W-1:0] key;
        int               idx;
        int               start;
        logic             was_newest;
        cmd_beat_t        tail;
        key   = {wifi, id[ID_BITS-1:0]};
        start = cmd_expected.size();
        idx   = find_speaker(key);
        if (req == REQ_CALL)
        begin
            // Calls on a channel outside the camera range are ignored.
            if (ch >= CH_MIN && ch <= CH_MAX)
            begin
                if (idx >= 0)
                    drop_speaker(idx);
                if (speaker_count >= DEPTH)
                    drop_speaker(0);
                speaker_key[speaker_count]     = key;
                speaker_channel[speaker_count] = ch;
                speaker_preset[speaker_count]  = pos;
                speaker_count++;
                aim_camera(ch, pos);
            end
        end
        else if (idx >= 0)
        begin
            // Only the release of the newest speaker moves the camera.
            was_newest = (idx == speaker_count - 1);
            drop_speaker(idx);
            if (was_newest)
            begin
                if (speaker_count > 0)
                    aim_camera(speaker_channel[speaker_count - 1],
                               speaker_preset[speaker_count - 1]);
                else
                    aim_camera(pan_channel, pan_preset);
            end
        end
        if (cmd_expected.size() > start)
        begin
            tail      = cmd_expected.pop_back();
            tail.last = 1'b1;
            cmd_expected.push_back(tail);
        end
    endfunction

    // Watch register writes, event transfers and command byte transfers.
    always @(posedge clk or negedge rst_n)
    begin
        cmd_beat_t want;
        if (!rst_n)
        begin
            speaker_count  = 0;
            live_channel   = '0;
            pan_channel    = 8'd1;
            pan_preset     = 8'd0;
            mismatch_count = 0;
            cmd_expected.delete();
            bytes_pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_PAN_CHANNEL)
                    pan_channel = pwdata[BYTE_W-1:0];
                else
                    pan_preset = pwdata[BYTE_W-1:0];
            end
            if (evt.valid && evt.ready)
                predict_event(evt.req_type, evt.unit_id, evt.is_wifi,
                              evt.cam_channel, evt.cam_preset);
            if (cmd.valid && cmd.ready)
            begin
                if (cmd_expected.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected command byte %02h eoc %0b last %0b",
                                 cmd.cmd_byte, cmd.end_of_command, cmd.last);
                end
                else
                begin
                    want = cmd_expected.pop_front();
                    if (cmd.cmd_byte !== want.data || cmd.end_of_command !== want.eoc ||
                        cmd.last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("byte mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                     want.data, want.eoc, want.last,
                                     cmd.cmd_byte, cmd.end_of_command, cmd.last);
                    end
                end
            end
            bytes_pending <= cmd_expected.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Stimulus and verdict for the camera tracking preset queue, with the checker beside the block.
module tb_top;
    import ctpq_pkg::*;

    localparam int KEY_W       = UNIT_ID_W + 1;
    localparam int POOL_SIZE   = 64;
    localparam int SETTLE_GAP  = 24;
    localparam int CYCLE_LIMIT = 300000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    int                fail_count;
    int                bytes_pending;
    int                cycle_count = 0;
    bit                idle_on;

    logic [KEY_W-1:0]  unit_pool [POOL_SIZE];
    logic [KEY_W-1:0]  recent_key;
    bit                recent_valid;

    ctpq_evt_if evt_bus ();
    ctpq_cmd_if cmd_bus ();

    camera_tracking_preset_queue_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt_bus),
        .cmd     (cmd_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ctpq_command_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .evt           (evt_bus),
        .cmd           (cmd_bus),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .bytes_pending (bytes_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run guard: a hung handshake ends the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // The command sink stalls at random while idling is enabled.
    always @(posedge clk)
        cmd_bus.ready <= idle_on ? ($urandom_range(99) >= 35) : 1'b1;

    // Present one event and hold it until its transfer; valid stays high afterwards.
    task automatic put_event(
        input logic                 req,
        input logic [UNIT_ID_W-1:0] id,
        input logic                 wifi,
        input logic [BYTE_W-1:0]    ch,
        input logic [BYTE_W-1:0]    pos
    );
        while (idle_on && $urandom_range(99) < 35)
        begin
            evt_bus.valid <= 1'b0;
            @(posedge clk);
        end
        evt_bus.valid       <= 1'b1;
        evt_bus.req_type    <= req;
        evt_bus.unit_id     <= id;
        evt_bus.is_wifi     <= wifi;
        evt_bus.cam_channel <= ch;
        evt_bus.cam_preset  <= pos;
        @(posedge clk);
        while (!evt_bus.ready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every expected byte has gone out and the block is quiet.
    task automatic settle();
        evt_bus.valid <= 1'b0;
        @(posedge clk);
        while (bytes_pending != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle; junk in the unused upper bits.
    task automatic write_reg(input logic reg_sel, input logic [BYTE_W-1:0] value);
        logic [23:0] junk;
        junk = 24'($urandom());
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {junk, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random calls and releases over the first pool_size units of the pool.
    task automatic run_phase(input int items, input int pool_size, input int release_pct);
        logic [KEY_W-1:0]  pick;
        logic [BYTE_W-1:0] ch;
        logic [BYTE_W-1:0] pos;
        for (int n = 0; n < items; n++)
        begin
            pick = unit_pool[$urandom_range(pool_size - 1)];
            pos  = BYTE_W'($urandom_range(255));
            if ($urandom_range(99) < release_pct)
            begin
                // Half the releases target the most recent caller, to move the camera back when it is still the newest.
                if (recent_valid && $urandom_range(1) == 1)
                    pick = recent_key;
                ch = BYTE_W'($urandom_range(255));
                put_event(REQ_RELEASE, pick[UNIT_ID_W-1:0], pick[UNIT_ID_W], ch, pos);
            end
            else
            begin
                if ($urandom_range(99) < 85)
                    ch = BYTE_W'($urandom_range(CH_MAX, CH_MIN));
                else
                    ch = BYTE_W'($urandom_range(255));
                put_event(REQ_CALL, pick[UNIT_ID_W-1:0], pick[UNIT_ID_W], ch, pos);
                recent_key   = pick;
                recent_valid = 1'b1;
            end
        end
    endtask

    initial
    begin
        idle_on      = 1'b1;
        recent_valid = 1'b0;
        recent_key   = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            unit_pool[i] = KEY_W'($urandom_range(2 ** KEY_W - 1));

        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        evt_bus.valid       <= 1'b0;
        evt_bus.req_type    <= REQ_CALL;
        evt_bus.unit_id     <= '0;
        evt_bus.is_wifi     <= 1'b0;
        evt_bus.cam_channel <= '0;
        evt_bus.cam_preset  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: out-of-range channels, re-calls, key separation, releases of every kind.
        put_event(REQ_CALL, 12'h000, 1'b0, 8'd0, 8'h11);
        put_event(REQ_CALL, 12'h000, 1'b0, 8'd6, 8'h22);
        put_event(REQ_CALL, 12'h000, 1'b0, 8'd255, 8'h33);
        put_event(REQ_CALL, 12'h000, 1'b0, 8'd1, 8'h00);
        put_event(REQ_CALL, 12'hFFF, 1'b1, 8'd5, 8'hFF);
        put_event(REQ_CALL, 12'hFFF, 1'b1, 8'd5, 8'h80);
        put_event(REQ_CALL, 12'hFFF, 1'b0, 8'd2, 8'h55);
        put_event(REQ_CALL, 12'hAAA, 1'b1, 8'd3, 8'hAA);
        put_event(REQ_CALL, 12'h555, 1'b0, 8'd4, 8'h55);
        put_event(REQ_RELEASE, 12'h123, 1'b0, 8'd9, 8'h00);
        put_event(REQ_RELEASE, 12'h000, 1'b0, 8'd0, 8'h00);
        put_event(REQ_RELEASE, 12'hAAA, 1'b1, 8'd0, 8'h00);
        put_event(REQ_RELEASE, 12'h555, 1'b0, 8'd0, 8'h00);
        put_event(REQ_RELEASE, 12'hFFF, 1'b0, 8'd0, 8'h00);
        put_event(REQ_RELEASE, 12'hFFF, 1'b1, 8'd0, 8'h00);
        put_event(REQ_RELEASE, 12'hFFF, 1'b1, 8'd0, 8'h00);
        put_event(REQ_CALL, 12'h001, 1'b0, 8'd1, 8'h01);
        put_event(REQ_RELEASE, 12'h001, 1'b0, 8'hFF, 8'hFF);

        // Panorama at channel zero and the top preset; small pool keeps units repeating.
        settle();
        write_reg(REG_PAN_CHANNEL, 8'd0);
        write_reg(REG_PAN_PRESET, 8'hFF);
        run_phase(55, 6, 40);

        // Long stretch with no stalls on either side.
        settle();
        idle_on = 1'b0;
        write_reg(REG_PAN_CHANNEL, 8'd255);
        write_reg(REG_PAN_PRESET, 8'd0);
        run_phase(55, 10, 40);

        // Mostly calls over a wide pool, so the list overflows and drops its oldest entries.
        settle();
        idle_on = 1'b1;
        write_reg(REG_PAN_CHANNEL, 8'd3);
        write_reg(REG_PAN_PRESET, 8'h5A);
        run_phase(70, 48, 15);
        for (int k = 47; k >= 0; k--)
            put_event(REQ_RELEASE, unit_pool[k][UNIT_ID_W-1:0], unit_pool[k][UNIT_ID_W],
                      8'd0, 8'd0);
        recent_valid = 1'b0;

        // Panorama on a valid camera channel, so the switch frame may be skipped.
        settle();
        write_reg(REG_PAN_CHANNEL, 8'd5);
        write_reg(REG_PAN_PRESET, 8'hFF);
        run_phase(55, 6, 45);

        settle();
        if (fail_count == 0 && bytes_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
